### rtl/core/ismf_pkg.sv
// Shared constants, types and index helpers for the Ising Metropolis flip block.
package ismf_pkg;

  localparam int SIDE       = 64;
  localparam int ROW_W      = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam int SITE_W     = 6;
  localparam int RND_W      = 32;
  localparam int DE_W       = 5;
  localparam int ENERGY_W   = 15;
  localparam int MAG_W      = 14;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int CNT_W      = 3;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_FLIP   = 2'd1;
  localparam logic [OP_W-1:0] OP_RECOMP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TH4     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TH8     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDERED = 2'd2;

  typedef logic [ROW_W-1:0] idx_t;
  typedef logic [SIDE-1:0]  row_word_t;

  typedef enum logic [1:0] {
    RD_IN    = 2'd0,
    RD_NORTH = 2'd1,
    RD_WALK  = 2'd2
  } rd_mode_t;

  typedef struct packed {
    logic     capture;
    logic     tot_clr;
    logic     rd_en;
    rd_mode_t rd_mode;
    logic     latch_nbr;
    logic     load_wr;
    logic     fill_wr;
    logic     walk_bit;
    logic     row_next;
    logic     finish_flip;
    logic     finish_plain;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] in_op;
    logic            in_inside;
    logic            ordered;
    logic            row_last;
    logic            col_last;
    logic            out_free;
  } stat_t;

  function automatic idx_t site_idx(input logic [SITE_W-1:0] v);
    logic [ROW_W+SITE_W-1:0] ext;
    ext = (ROW_W+SITE_W)'(v);
    return ext[ROW_W-1:0];
  endfunction

  function automatic logic site_inside(input logic [SITE_W-1:0] v);
    logic [ROW_W+SITE_W:0] ext;
    ext = (ROW_W+SITE_W+1)'(v);
    return ext < (ROW_W+SITE_W+1)'(SIDE);
  endfunction

  function automatic idx_t idx_inc(input idx_t i);
    return (i == ROW_W'(SIDE - 1)) ? '0 : i + ROW_W'(1);
  endfunction

  function automatic idx_t idx_dec(input idx_t i);
    return (i == '0) ? ROW_W'(SIDE - 1) : i - ROW_W'(1);
  endfunction

endpackage

### rtl/core/ismf_ctrl.sv
// Sequencer for the Ising flip block: decodes transactions and steps the datapath.
module ismf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ismf_pkg::stat_t stat,
  output ismf_pkg::cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_FLIP_RD   = 8'b0000_0010,
    S_FLIP_EVAL = 8'b0000_0100,
    S_LOAD_WR   = 8'b0000_1000,
    S_FILL      = 8'b0001_0000,
    S_WALK_RD   = 8'b0010_0000,
    S_WALK_BIT  = 8'b0100_0000,
    S_DONE      = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt        = state_r;
    cmd              = '0;
    cmd.rd_mode      = ismf_pkg::RD_IN;
    unique case (state_r)
      S_IDLE: begin
        cmd.rd_en   = in_valid;
        cmd.capture = accept;
        if (accept) begin
          if (stat.in_op == ismf_pkg::OP_FLIP && stat.in_inside) begin
            state_nxt = S_FLIP_RD;
          end else if (stat.in_op == ismf_pkg::OP_LOAD && stat.in_inside) begin
            state_nxt = S_LOAD_WR;
          end else if (stat.in_op == ismf_pkg::OP_RECOMP) begin
            cmd.tot_clr = 1'b1;
            state_nxt   = stat.ordered ? S_FILL : S_WALK_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_FLIP_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_mode   = ismf_pkg::RD_NORTH;
        cmd.latch_nbr = 1'b1;
        state_nxt     = S_FLIP_EVAL;
      end
      S_FLIP_EVAL: begin
        if (stat.out_free) begin
          cmd.finish_flip = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_LOAD_WR: begin
        if (stat.out_free) begin
          cmd.load_wr      = 1'b1;
          cmd.finish_plain = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_FILL: begin
        cmd.fill_wr  = 1'b1;
        cmd.row_next = 1'b1;
        if (stat.row_last) begin
          state_nxt = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_mode = ismf_pkg::RD_WALK;
        state_nxt   = S_WALK_BIT;
      end
      S_WALK_BIT: begin
        cmd.walk_bit = 1'b1;
        if (stat.col_last) begin
          cmd.row_next = 1'b1;
          state_nxt    = stat.row_last ? S_DONE : S_WALK_RD;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish_plain = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/ismf_dp.sv
// Datapath for the Ising flip block: lattice memory, totals, config and result registers.
module ismf_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ismf_pkg::cmd_t                         cmd,
  output ismf_pkg::stat_t                        stat,
  input  logic [ismf_pkg::OP_W-1:0]              in_opcode,
  input  logic [ismf_pkg::SITE_W-1:0]            in_site_row,
  input  logic [ismf_pkg::SITE_W-1:0]            in_site_col,
  input  logic                                   in_spin_up,
  input  logic [ismf_pkg::RND_W-1:0]             in_random_fraction,
  input  logic                                   cfg_we,
  input  logic [ismf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ismf_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_accepted,
  output logic signed [ismf_pkg::DE_W-1:0]       out_delta_energy,
  output logic signed [ismf_pkg::ENERGY_W-1:0]   out_total_energy,
  output logic signed [ismf_pkg::MAG_W-1:0]      out_magnetization
);

  localparam int ROW_W    = ismf_pkg::ROW_W;
  localparam int ENERGY_W = ismf_pkg::ENERGY_W;
  localparam int MAG_W    = ismf_pkg::MAG_W;
  localparam int DE_W     = ismf_pkg::DE_W;
  localparam int CNT_W    = ismf_pkg::CNT_W;

  // lattice: one word per row
  ismf_pkg::row_word_t lattice_mem [ismf_pkg::SIDE];

  ismf_pkg::row_word_t rd_a_r;
  ismf_pkg::row_word_t rd_b_r;
  ismf_pkg::row_word_t center_r;
  ismf_pkg::row_word_t south_r;
  ismf_pkg::idx_t      rd_a_addr;
  ismf_pkg::idx_t      rd_b_addr;

  logic                  wr_en;
  ismf_pkg::idx_t        wr_addr;
  ismf_pkg::row_word_t   wr_data;

  logic [ismf_pkg::RND_W-1:0]      th4_r;
  logic [ismf_pkg::RND_W-1:0]      th8_r;
  logic                            ordered_r;

  ismf_pkg::idx_t                  row_r;
  ismf_pkg::idx_t                  col_r;
  logic                            spin_r;
  logic [ismf_pkg::RND_W-1:0]      rnd_r;
  ismf_pkg::idx_t                  row_cnt_r;
  ismf_pkg::idx_t                  col_cnt_r;

  logic signed [ENERGY_W-1:0]      energy_total_r;
  logic signed [ENERGY_W-1:0]      energy_total_nxt;
  logic signed [MAG_W-1:0]         spin_sum_r;
  logic signed [MAG_W-1:0]         spin_sum_nxt;

  logic                            out_valid_r;
  logic                            acc_r;
  logic signed [DE_W-1:0]          de_r;
  logic signed [ENERGY_W-1:0]      out_energy_r;
  logic signed [MAG_W-1:0]         out_mag_r;
  logic                            out_free;

  // flip evaluation
  ismf_pkg::idx_t                  col_e;
  ismf_pkg::idx_t                  col_w;
  logic                            s_bit;
  logic [CNT_W-1:0]                n_eq;
  logic signed [DE_W-1:0]          flip_de;
  logic                            flip_ok;
  ismf_pkg::row_word_t             flip_word;
  ismf_pkg::row_word_t             load_word;

  // recompute walk
  ismf_pkg::idx_t                  col_left;
  logic                            w_s;
  logic [1:0]                      w_eq;

  assign out_free = !out_valid_r || !out_stall;

  assign stat.in_op     = in_opcode;
  assign stat.in_inside = ismf_pkg::site_inside(in_site_row) &&
                          ismf_pkg::site_inside(in_site_col);
  assign stat.ordered   = ordered_r;
  assign stat.row_last  = (row_cnt_r == ROW_W'(ismf_pkg::SIDE - 1));
  assign stat.col_last  = (col_cnt_r == ROW_W'(ismf_pkg::SIDE - 1));
  assign stat.out_free  = out_free;

  always_comb begin
    rd_a_addr = ismf_pkg::site_idx(in_site_row);
    rd_b_addr = ismf_pkg::idx_dec(ismf_pkg::site_idx(in_site_row));
    unique case (cmd.rd_mode)
      ismf_pkg::RD_IN: begin
        rd_a_addr = ismf_pkg::site_idx(in_site_row);
        rd_b_addr = ismf_pkg::idx_dec(ismf_pkg::site_idx(in_site_row));
      end
      ismf_pkg::RD_NORTH: begin
        rd_a_addr = ismf_pkg::idx_inc(row_r);
        rd_b_addr = row_r;
      end
      ismf_pkg::RD_WALK: begin
        rd_a_addr = row_cnt_r;
        rd_b_addr = ismf_pkg::idx_dec(row_cnt_r);
      end
      default: begin
        rd_a_addr = row_r;
        rd_b_addr = row_r;
      end
    endcase
  end

  // flip: center row, south from port B, north from the second read
  always_comb begin
    col_e   = ismf_pkg::idx_inc(col_r);
    col_w   = ismf_pkg::idx_dec(col_r);
    s_bit   = center_r[col_r];
    n_eq    = CNT_W'(center_r[col_e] == s_bit) + CNT_W'(center_r[col_w] == s_bit) +
              CNT_W'(rd_a_r[col_r] == s_bit) + CNT_W'(south_r[col_r] == s_bit);
    case (n_eq)
      3'd0:    flip_de = -DE_W'(8);
      3'd1:    flip_de = -DE_W'(4);
      3'd2:    flip_de = DE_W'(0);
      3'd3:    flip_de = DE_W'(4);
      default: flip_de = DE_W'(8);
    endcase
    if (n_eq <= 3'd2) begin
      flip_ok = 1'b1;
    end else if (n_eq == 3'd3) begin
      flip_ok = (rnd_r <= th4_r);
    end else begin
      flip_ok = (rnd_r <= th8_r);
    end
    flip_word        = center_r;
    flip_word[col_r] = ~s_bit;
    load_word        = rd_a_r;
    load_word[col_r] = spin_r;
  end

  always_comb begin
    col_left = ismf_pkg::idx_dec(col_cnt_r);
    w_s      = rd_a_r[col_cnt_r];
    w_eq     = 2'(rd_b_r[col_cnt_r] == w_s) + 2'(rd_a_r[col_left] == w_s);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = row_r;
    wr_data = load_word;
    if (cmd.load_wr) begin
      wr_en = 1'b1;
    end else if (cmd.finish_flip) begin
      wr_en   = flip_ok;
      wr_data = flip_word;
    end else if (cmd.fill_wr) begin
      wr_en   = 1'b1;
      wr_addr = row_cnt_r;
      wr_data = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lattice_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_a_r <= lattice_mem[rd_a_addr];
      rd_b_r <= lattice_mem[rd_b_addr];
    end
  end

  always_comb begin
    energy_total_nxt = energy_total_r;
    spin_sum_nxt     = spin_sum_r;
    if (cmd.tot_clr) begin
      energy_total_nxt = '0;
      spin_sum_nxt     = '0;
    end else if (cmd.walk_bit) begin
      spin_sum_nxt = w_s ? spin_sum_r + MAG_W'(1) : spin_sum_r - MAG_W'(1);
      case (w_eq)
        2'd0:    energy_total_nxt = energy_total_r + ENERGY_W'(2);
        2'd1:    energy_total_nxt = energy_total_r;
        default: energy_total_nxt = energy_total_r - ENERGY_W'(2);
      endcase
    end else if (cmd.finish_flip && flip_ok) begin
      energy_total_nxt = energy_total_r + ENERGY_W'(flip_de);
      spin_sum_nxt     = s_bit ? spin_sum_r - MAG_W'(2) : spin_sum_r + MAG_W'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_r  <= ismf_pkg::site_idx(in_site_row);
      col_r  <= ismf_pkg::site_idx(in_site_col);
      spin_r <= in_spin_up;
      rnd_r  <= in_random_fraction;
    end
    if (cmd.latch_nbr) begin
      center_r <= rd_a_r;
      south_r  <= rd_b_r;
    end
    if (cmd.finish_flip) begin
      acc_r        <= flip_ok;
      de_r         <= flip_de;
      out_energy_r <= energy_total_nxt;
      out_mag_r    <= spin_sum_nxt;
    end else if (cmd.finish_plain) begin
      acc_r        <= 1'b0;
      de_r         <= '0;
      out_energy_r <= energy_total_r;
      out_mag_r    <= spin_sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      th4_r          <= '0;
      th8_r          <= '0;
      ordered_r      <= 1'b0;
      energy_total_r <= '0;
      spin_sum_r     <= '0;
      row_cnt_r      <= '0;
      col_cnt_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ismf_pkg::CFG_TH4:     th4_r     <= cfg_wdata;
          ismf_pkg::CFG_TH8:     th8_r     <= cfg_wdata;
          ismf_pkg::CFG_ORDERED: ordered_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      energy_total_r <= energy_total_nxt;
      spin_sum_r     <= spin_sum_nxt;
      if (cmd.capture) begin
        row_cnt_r <= '0;
        col_cnt_r <= '0;
      end else begin
        if (cmd.row_next) begin
          row_cnt_r <= ismf_pkg::idx_inc(row_cnt_r);
        end
        if (cmd.walk_bit) begin
          col_cnt_r <= ismf_pkg::idx_inc(col_cnt_r);
        end
      end
      if (cmd.finish_flip || cmd.finish_plain) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = acc_r;
  assign out_delta_energy  = de_r;
  assign out_total_energy  = out_energy_r;
  assign out_magnetization = out_mag_r;

  a_finish_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish_flip || cmd.finish_plain) |-> out_free)
    else $error("result finished while output slot busy");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_wr, cmd.fill_wr, cmd.finish_flip}))
    else $error("more than one lattice write source");

  a_walk_operands_stable: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_bit |-> !cmd.rd_en)
    else $error("row read issued during recompute walk");

  a_flip_moves_mag: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish_flip && flip_ok) |=>
      ((spin_sum_r - $past(spin_sum_r)) == MAG_W'(2) ||
       (spin_sum_r - $past(spin_sum_r)) == -MAG_W'(2)))
    else $error("accepted flip did not move magnetization by two");

  a_reject_positive_de: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !acc_r && de_r != '0) |-> (de_r > 0))
    else $error("rejected flip with non-positive energy change");

endmodule

### rtl/core/ising_lattice_metropolis_flip.sv
// Top level of the Ising lattice Metropolis flip block.
// The SIDE x SIDE lattice lives in a memory of SIDE row words with two registered read
// ports; a flip needs the center row and its two wrapped neighbor rows, fetched by two
// reads, so a flip steps through idle, neighbor read and evaluate; a spin load does a
// read-modify-write of its row and an unused opcode goes straight to done. A recompute
// walks the lattice one site per cycle after each row read, preceded by all-ones
// row writes when the ordered config bit is set. Input is taken only while the block
// is idle; a finished result waits in the output register and the next transaction
// runs on until it must deliver its own result. Load does not update the totals.
module ising_lattice_metropolis_flip (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [ismf_pkg::OP_W-1:0]              in_opcode,
  input  logic [ismf_pkg::SITE_W-1:0]            in_site_row,
  input  logic [ismf_pkg::SITE_W-1:0]            in_site_col,
  input  logic                                   in_spin_up,
  input  logic [ismf_pkg::RND_W-1:0]             in_random_fraction,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_accepted,
  output logic signed [ismf_pkg::DE_W-1:0]       out_delta_energy,
  output logic signed [ismf_pkg::ENERGY_W-1:0]   out_total_energy,
  output logic signed [ismf_pkg::MAG_W-1:0]      out_magnetization,
  input  logic                                   cfg_we,
  input  logic [ismf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ismf_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  ismf_pkg::cmd_t  cmd;
  ismf_pkg::stat_t stat;

  ismf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ismf_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_opcode          (in_opcode),
    .in_site_row        (in_site_row),
    .in_site_col        (in_site_col),
    .in_spin_up         (in_spin_up),
    .in_random_fraction (in_random_fraction),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_accepted       (out_accepted),
    .out_delta_energy   (out_delta_energy),
    .out_total_energy   (out_total_energy),
    .out_magnetization  (out_magnetization)
  );

endmodule

### bench/tb.sv
// Self-checking testbench for the Ising lattice Metropolis flip block.
`timescale 1ns / 1ps

module tb;
  import ismf_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int ITEMS_PER_SETTING = 130;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SITE_W-1:0] row;
    logic [SITE_W-1:0] col;
    logic              up;
    logic [RND_W-1:0]  rnd;
  } spin_cmd_t;

  typedef struct packed {
    logic                       acc;
    logic signed [DE_W-1:0]     de;
    logic signed [ENERGY_W-1:0] energy;
    logic signed [MAG_W-1:0]    mag;
  } spin_report_t;

  typedef struct packed {
    spin_cmd_t    cmd;
    logic         typed;
    spin_report_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [OP_W-1:0] in_opcode;
  logic [SITE_W-1:0] in_site_row;
  logic [SITE_W-1:0] in_site_col;
  logic in_spin_up;
  logic [RND_W-1:0] in_random_fraction;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_accepted;
  logic signed [DE_W-1:0] out_delta_energy;
  logic signed [ENERGY_W-1:0] out_total_energy;
  logic signed [MAG_W-1:0] out_magnetization;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // model state
  logic lattice_up [SIDE][SIDE];
  logic signed [ENERGY_W-1:0] energy_sum;
  logic signed [MAG_W-1:0] spin_total;
  logic [RND_W-1:0] thr4;
  logic [RND_W-1:0] thr8;
  logic ordered_fill;

  spin_report_t awaited_reports[$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  dir_row_t dir_rows [16] = '{
    '{'{OP_UNUSED, 6'd0, 6'd0, 1'b0, 32'd0}, 1'b1, '{1'b0, 5'sd0, 15'sd0, 14'sd0}},
    '{'{OP_LOAD, 6'd0, 6'd0, 1'b0, 32'd0}, 1'b1, '{1'b0, 5'sd0, 15'sd0, 14'sd0}},
    '{'{OP_LOAD, 6'd63, 6'd63, 1'b1, 32'd0}, 1'b1, '{1'b0, 5'sd0, 15'sd0, 14'sd0}},
    '{'{OP_RECOMP, 6'd0, 6'd0, 1'b0, 32'd0}, 1'b1,
      '{1'b0, 5'sd0, -15'sd8192, 14'sd4096}},
    '{'{OP_FLIP, 6'd0, 6'd0, 1'b0, 32'd0}, 1'b1,
      '{1'b1, 5'sd8, -15'sd8184, 14'sd4094}},
    '{'{OP_FLIP, 6'd0, 6'd0, 1'b0, 32'hFFFF_FFFF}, 1'b1,
      '{1'b1, -5'sd8, -15'sd8192, 14'sd4096}},
    '{'{OP_FLIP, 6'd63, 6'd63, 1'b0, 32'd1}, 1'b1,
      '{1'b0, 5'sd8, -15'sd8192, 14'sd4096}},
    '{'{OP_FLIP, 6'd0, 6'd63, 1'b1, 32'hFFFF_FFFF}, 1'b1,
      '{1'b0, 5'sd8, -15'sd8192, 14'sd4096}},
    '{'{OP_LOAD, 6'd0, 6'd1, 1'b0, 32'd0}, 1'b0, '0},
    '{'{OP_FLIP, 6'd0, 6'd0, 1'b0, 32'h8000_0000}, 1'b0, '0},
    '{'{OP_FLIP, 6'd0, 6'd0, 1'b0, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{OP_FLIP, 6'd0, 6'd0, 1'b0, 32'h8000_0001}, 1'b0, '0},
    '{'{OP_LOAD, 6'd1, 6'd0, 1'b0, 32'd0}, 1'b0, '0},
    '{'{OP_FLIP, 6'd0, 6'd0, 1'b0, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{OP_UNUSED, 6'd63, 6'd0, 1'b1, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{OP_RECOMP, 6'd63, 6'd63, 1'b1, 32'd0}, 1'b0, '0}
  };

  ising_lattice_metropolis_flip dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int spin_of(int r, int c);
    return lattice_up[r][c] ? 1 : -1;
  endfunction

  function automatic spin_report_t metropolis_step(spin_cmd_t c);
    spin_report_t rep;
    int r, k, s, nsum, de, e, m;
    logic ok;
    rep = '0;
    r = int'(c.row);
    k = int'(c.col);
    case (c.op)
      OP_LOAD: begin
        if (r < SIDE && k < SIDE) lattice_up[r][k] = c.up;
      end
      OP_FLIP: begin
        if (r < SIDE && k < SIDE) begin
          s = spin_of(r, k);
          nsum = spin_of(r, (k + 1) % SIDE) + spin_of(r, (k + SIDE - 1) % SIDE)
               + spin_of((r + SIDE - 1) % SIDE, k) + spin_of((r + 1) % SIDE, k);
          de = 2 * s * nsum;
          if (de <= 0) ok = 1'b1;
          else if (de == 4) ok = (c.rnd <= thr4);
          else ok = (c.rnd <= thr8);
          if (ok) begin
            lattice_up[r][k] = (s < 0);
            spin_total = spin_total + MAG_W'(-2 * s);
            energy_sum = energy_sum + ENERGY_W'(de);
          end
          rep.acc = ok;
          rep.de = DE_W'(de);
        end
      end
      OP_RECOMP: begin
        e = 0;
        m = 0;
        if (ordered_fill) begin
          for (int i = 0; i < SIDE; i++)
            for (int j = 0; j < SIDE; j++) lattice_up[i][j] = 1'b1;
        end
        for (int i = 0; i < SIDE; i++) begin
          for (int j = 0; j < SIDE; j++) begin
            m += spin_of(i, j);
            e -= spin_of(i, j) * (spin_of((i + SIDE - 1) % SIDE, j)
                                  + spin_of(i, (j + SIDE - 1) % SIDE));
          end
        end
        energy_sum = ENERGY_W'(e);
        spin_total = MAG_W'(m);
      end
      default: ;
    endcase
    rep.energy = energy_sum;
    rep.mag = spin_total;
    return rep;
  endfunction

  task automatic send_cmd(spin_cmd_t c, logic typed, spin_report_t want);
    spin_report_t pred;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_opcode = c.op;
    in_site_row = c.row;
    in_site_col = c.col;
    in_spin_up = c.up;
    in_random_fraction = c.rnd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = metropolis_step(c);
    awaited_reports.push_back(typed ? want : pred);
  endtask

  task automatic drain(int extra);
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_config(logic [RND_W-1:0] th4, logic [RND_W-1:0] th8, logic ordered);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = CFG_TH4;
    cfg_wdata = th4;
    @(negedge clk);
    cfg_index = CFG_TH8;
    cfg_wdata = th8;
    @(negedge clk);
    cfg_index = CFG_ORDERED;
    cfg_wdata = CFG_DATA_W'(ordered);
    @(negedge clk);
    cfg_we = 1'b0;
    thr4 = th4;
    thr8 = th8;
    ordered_fill = ordered;
  endtask

  task automatic check_field(string name, int want, int seen);
    if (want != seen) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      mismatches++;
    end
  endtask

  always @(negedge clk) out_stall = ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk) begin
    spin_report_t exp_rep;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_reports.size() == 0) begin
        $display("%0t ns: unexpected transaction, expected none, actual E=%0d M=%0d",
                 $time, out_total_energy, out_magnetization);
        mismatches++;
      end else begin
        exp_rep = awaited_reports.pop_front();
        check_field("accepted", exp_rep.acc, out_accepted);
        check_field("delta_energy", exp_rep.de, out_delta_energy);
        check_field("total_energy", exp_rep.energy, out_total_energy);
        check_field("magnetization", exp_rep.mag, out_magnetization);
      end
    end
  end

  initial begin
    spin_cmd_t c;
    int pick;
    int hot_r;
    int hot_c;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_LOAD;
    in_site_row = '0;
    in_site_col = '0;
    in_spin_up = 1'b0;
    in_random_fraction = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_TH4;
    cfg_wdata = '0;
    energy_sum = '0;
    spin_total = '0;
    thr4 = '0;
    thr8 = '0;
    ordered_fill = 1'b0;
    hot_r = 0;
    hot_c = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 37;
    recv_idle_pct = 54;
    // ordered recompute fills the whole lattice before any flip reads it
    write_config(32'h8000_0000, 32'd0, 1'b1);
    foreach (dir_rows[i]) send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);

    for (int setting = 0; setting < 6; setting++) begin
      drain(10);
      case (setting / 2)
        0: begin send_idle_pct = 37; recv_idle_pct = 54; end
        1: begin send_idle_pct = 54; recv_idle_pct = 37; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (setting)
        0: write_config($urandom, $urandom, 1'b0);
        1: write_config(32'hFFFF_FFFF, 32'd0, 1'b1);
        2: write_config(32'd0, 32'hFFFF_FFFF, 1'b0);
        3: write_config($urandom, $urandom, 1'b1);
        4: write_config(32'h8000_0000, 32'h4000_0000, 1'b0);
        default: write_config($urandom, $urandom, 1'($urandom_range(1)));
      endcase
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        pick = $urandom_range(99);
        if (pick < 40) c.op = OP_LOAD;
        else if (pick < 90) c.op = OP_FLIP;
        else if (pick < 95) c.op = OP_UNUSED;
        else c.op = OP_RECOMP;
        // a small hot window keeps loads and flips interacting
        if ($urandom_range(31) == 0) begin
          hot_r = $urandom_range(SIDE - 1);
          hot_c = $urandom_range(SIDE - 1);
        end
        pick = $urandom_range(99);
        if (pick < 45) begin
          c.row = SITE_W'((hot_r + $urandom_range(3)) % SIDE);
          c.col = SITE_W'((hot_c + $urandom_range(3)) % SIDE);
        end else if (pick < 60) begin
          c.row = $urandom_range(1) ? SITE_W'(SIDE - 1) : '0;
          c.col = $urandom_range(1) ? SITE_W'(SIDE - 1) : SITE_W'($urandom_range(SIDE - 1));
        end else begin
          c.row = SITE_W'($urandom_range(SIDE - 1));
          c.col = SITE_W'($urandom_range(SIDE - 1));
        end
        c.up = 1'($urandom_range(1));
        case ($urandom_range(9))
          0: c.rnd = '0;
          1: c.rnd = '1;
          2, 3: c.rnd = thr4 + RND_W'($urandom_range(2)) - RND_W'(1);
          4, 5: c.rnd = thr8 + RND_W'($urandom_range(2)) - RND_W'(1);
          default: c.rnd = $urandom;
        endcase
        send_cmd(c, 1'b0, '0);
      end
    end
    @(negedge clk);
    in_valid = 1'b0;
    drain(20);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
